// ----- rtl/macro_instruction_expander_unit_defines.svh -----
// Assertion helpers for the macro-instruction expander
`ifndef MACRO_INSTRUCTION_EXPANDER_UNIT_DEFINES_SVH
`define MACRO_INSTRUCTION_EXPANDER_UNIT_DEFINES_SVH

// same-cycle implication
`define MIE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MIE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/mie_pkg.sv -----
`default_nettype none
package mie_pkg;
   localparam logic [1:0] OP_WRITE  = 2'd0;
   localparam logic [1:0] OP_CLEAR  = 2'd1;
   localparam logic [1:0] OP_UPDATE = 2'd2;

   localparam logic [7:0] OPC_MICRO  = 8'd0;
   localparam logic [7:0] OPC_MEAS   = 8'd1;
   localparam logic [7:0] OPC_BRANCH = 8'd2;
   localparam logic [7:0] BR_LOOP    = 8'd1;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_DONE = 2'd1;
   localparam logic [1:0] ST_ERR  = 2'd2;

   localparam logic CSR_TEST_MODE   = 1'b0;
   localparam logic CSR_TEST_RESULT = 1'b1;

   localparam int WALK_LIMIT = 64;
   localparam int VW = 7;

   typedef logic [1:0] status_type;
endpackage
`default_nettype wire

// ----- rtl/mie_ifs.sv -----
`default_nettype none
interface mie_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [1:0]  channel;
   logic [7:0]  entry_addr;
   logic        half_sel;
   logic [63:0] write_word;
   logic [8:0]  entry_count;
   logic [4:0]  capacity;
   logic        camera_ready;
   modport source (output valid, op, channel, entry_addr, half_sel, write_word,
                   entry_count, capacity, camera_ready, input ready);
   modport sink (input valid, op, channel, entry_addr, half_sel, write_word,
                 entry_count, capacity, camera_ready, output ready);
endinterface

interface mie_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [63:0] micro_lo;
   logic [63:0] micro_hi;
   logic [4:0]  produced_count;
   logic [1:0]  status;
   logic        measured;
   logic        last;
   modport source (output valid, kind, micro_lo, micro_hi, produced_count, status,
                   measured, last, input ready);
   modport sink (input valid, kind, micro_lo, micro_hi, produced_count, status,
                 measured, last, output ready);
endinterface

interface mie_csr_if;
   logic valid;
   logic ready;
   logic addr;
   logic wdata;
   modport source (output valid, addr, wdata, input ready);
   modport sink (input valid, addr, wdata, output ready);
endinterface
`default_nettype wire

// ----- rtl/macro_instruction_expander_unit.sv -----
// Sequencing: write and clear beats complete on acceptance. An update steps through
// S_CHECK and S_EXEC per entry visited, S_CPY and S_CPW per micro-instruction copied
// by a branch plus S_CPY after each block, and S_STAT for the status beat; held results stall it.
// Throughput: one request at a time; req ready returns the cycle after the status beat loads.
// Reset: synchronous, active high; clears channel states, config and handshakes.
// Program store contents are undefined after reset until written.
`default_nettype none
`include "macro_instruction_expander_unit_defines.svh"
module macro_instruction_expander_unit #(
   parameter int CHANNELS    = 4,
   parameter int STORE_DEPTH = 256,
   parameter int MAX_BATCH   = 16,
   parameter int ENTRY_BITS  = 128
) (
   input wire logic  clock,
   input wire logic  reset,
   mie_req_if.sink   req_bus,
   mie_rsp_if.source rsp_bus,
   mie_csr_if.sink   csr_bus
);
   import mie_pkg::*;

   localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int AW = $clog2(STORE_DEPTH);
   localparam int MW = CW + AW;
   localparam int MEM_DEPTH = 1 << MW;
   localparam int NW = $clog2(STORE_DEPTH + 1);
   localparam int KW = $clog2(MAX_BATCH + 1);
   localparam logic [63:0] HI_MASK = (ENTRY_BITS >= 128) ? {64{1'b1}} :
                                     ((64'd1 << (ENTRY_BITS - 64)) - 64'd1);

   typedef enum logic [2:0] {
      S_IDLE, S_CHECK, S_EXEC, S_CPY, S_CPW, S_STAT
   } state_type;

   state_type        state_ff;
   logic [15:0]      pc_ff [CHANNELS];
   logic [15:0]      iter_ff [CHANNELS];
   logic             loop_ff [CHANNELS];
   logic             meas_ff [CHANNELS];
   logic             test_mode_ff, test_result_ff;
   logic [CW-1:0]    ch_ff;
   logic             bad_ff, cam_ff;
   logic [NW-1:0]    n_ff;
   logic [KW-1:0]    cap_ff, k_ff;
   logic [VW-1:0]    visits_ff;
   logic [16:0]      idx_ff;
   logic [15:0]      cnt_ff;
   status_type       st_ff;

   logic             rsp_valid_ff, rsp_kind_ff, rsp_meas_ff, rsp_last_ff;
   logic [63:0]      rsp_lo_ff, rsp_hi_ff;
   logic [4:0]       rsp_cnt_ff;
   status_type       rsp_st_ff;

   logic [63:0]      mem_lo [MEM_DEPTH];
   logic [63:0]      mem_hi [MEM_DEPTH];
   logic [63:0]      rd_lo_ff, rd_hi_ff;

   logic             req_fire, ch_ok, wr_go, rd_go, out_free, walk_go, copy_go, rsp_load;
   logic [MW-1:0]    wr_addr, rd_addr;
   logic [15:0]      pc_cur;
   logic [16:0]      n_ext;

   assign req_bus.ready = (state_ff == S_IDLE);
   assign csr_bus.ready = 1'b1;
   assign req_fire = req_bus.valid && req_bus.ready;
   assign ch_ok    = (32'(req_bus.channel) < CHANNELS);
   assign wr_go    = req_fire && (req_bus.op == OP_WRITE) && ch_ok &&
                     (32'(req_bus.entry_addr) < STORE_DEPTH);
   assign wr_addr  = {CW'(req_bus.channel), AW'(req_bus.entry_addr)};

   assign pc_cur   = pc_ff[ch_ff];
   assign n_ext    = 17'(n_ff);
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign walk_go  = ({1'b0, pc_cur} < n_ext) && (k_ff < cap_ff);
   assign copy_go  = (cnt_ff != 16'd0) && (k_ff < cap_ff) && (idx_ff < n_ext);
   assign rsp_load = out_free && ((state_ff == S_CPW) || (state_ff == S_STAT) ||
                     ((state_ff == S_EXEC) && (rd_hi_ff[63:56] == OPC_MICRO)));

   always_comb begin
      rd_go   = 1'b0;
      rd_addr = {ch_ff, pc_cur[AW-1:0]};
      case (state_ff)
         S_CHECK: begin
            rd_go = walk_go && (32'(visits_ff) < WALK_LIMIT);
         end
         S_CPY: begin
            rd_go   = copy_go;
            rd_addr = {ch_ff, idx_ff[AW-1:0]};
         end
         default: begin
            rd_go = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_go) begin
         if (req_bus.half_sel) begin
            mem_hi[wr_addr] <= req_bus.write_word & HI_MASK;
         end else begin
            mem_lo[wr_addr] <= req_bus.write_word;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_go) begin
         rd_lo_ff <= mem_lo[rd_addr];
         rd_hi_ff <= mem_hi[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         test_mode_ff   <= 1'b0;
         test_result_ff <= 1'b0;
      end else if (csr_bus.valid && csr_bus.ready) begin
         if (csr_bus.addr == CSR_TEST_MODE) begin
            test_mode_ff <= csr_bus.wdata;
         end else begin
            test_result_ff <= csr_bus.wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      logic [7:0]  opc, btype;
      logic [15:0] nxt, fa, fb, fc, fd, itv, itn;
      opc   = rd_hi_ff[63:56];
      btype = rd_hi_ff[55:48];
      nxt   = rd_hi_ff[47:32];
      fa    = rd_hi_ff[31:16];
      fb    = rd_hi_ff[15:0];
      fc    = rd_lo_ff[63:48];
      fd    = rd_lo_ff[47:32];
      itv   = loop_ff[ch_ff] ? iter_ff[ch_ff] : fb;
      itn   = itv - 16'd1;
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < CHANNELS; c++) begin
            pc_ff[c]   <= '0;
            iter_ff[c] <= '0;
            loop_ff[c] <= 1'b0;
            meas_ff[c] <= 1'b0;
         end
      end else begin
         if (rsp_bus.ready && !rsp_load) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  ch_ff     <= CW'(req_bus.channel);
                  bad_ff    <= !ch_ok;
                  cam_ff    <= req_bus.camera_ready;
                  k_ff      <= '0;
                  visits_ff <= '0;
                  n_ff      <= (32'(req_bus.entry_count) > STORE_DEPTH) ?
                               NW'(STORE_DEPTH) : NW'(req_bus.entry_count);
                  cap_ff    <= (32'(req_bus.capacity) > MAX_BATCH) ?
                               KW'(MAX_BATCH) : KW'(req_bus.capacity);
                  case (req_bus.op)
                     OP_CLEAR: begin
                        for (int c = 0; c < CHANNELS; c++) begin
                           pc_ff[c]   <= '0;
                           iter_ff[c] <= '0;
                           loop_ff[c] <= 1'b0;
                           meas_ff[c] <= 1'b0;
                        end
                     end
                     OP_UPDATE: begin
                        if (ch_ok) begin
                           state_ff <= S_CHECK;
                        end else begin
                           st_ff    <= ST_ERR;
                           state_ff <= S_STAT;
                        end
                     end
                     default: begin
                        state_ff <= S_IDLE;
                     end
                  endcase
               end
            end
            S_CHECK: begin
               if (!walk_go) begin
                  st_ff    <= (({1'b0, pc_cur} >= n_ext) || (k_ff == '0)) ? ST_DONE : ST_OK;
                  state_ff <= S_STAT;
               end else if (32'(visits_ff) >= WALK_LIMIT) begin
                  st_ff    <= ST_OK;
                  state_ff <= S_STAT;
               end else begin
                  visits_ff <= visits_ff + VW'(1);
                  state_ff  <= S_EXEC;
               end
            end
            S_EXEC: begin
               case (opc)
                  OPC_MICRO: begin
                     if (out_free) begin
                        rsp_valid_ff  <= 1'b1;
                        rsp_kind_ff   <= 1'b0;
                        rsp_lo_ff     <= rd_lo_ff;
                        rsp_hi_ff     <= rd_hi_ff;
                        rsp_cnt_ff    <= '0;
                        rsp_st_ff     <= ST_OK;
                        rsp_meas_ff   <= 1'b0;
                        rsp_last_ff   <= 1'b0;
                        k_ff          <= k_ff + KW'(1);
                        pc_ff[ch_ff]  <= pc_cur + 16'd1;
                        if (k_ff + KW'(1) == cap_ff) begin
                           st_ff    <= ST_OK;
                           state_ff <= S_STAT;
                        end else begin
                           state_ff <= S_CHECK;
                        end
                     end
                  end
                  OPC_MEAS: begin
                     if (k_ff != '0) begin
                        st_ff    <= ST_OK;
                        state_ff <= S_STAT;
                     end else begin
                        meas_ff[ch_ff] <= test_mode_ff ? test_result_ff : cam_ff;
                        pc_ff[ch_ff]   <= pc_cur + 16'd1;
                        state_ff       <= S_CHECK;
                     end
                  end
                  OPC_BRANCH: begin
                     if ((btype == BR_LOOP) && (fa != 16'd0) && (fb != 16'd0)) begin
                        idx_ff         <= {1'b0, fc};
                        cnt_ff         <= fa;
                        iter_ff[ch_ff] <= itn;
                        if (itn != 16'd0) begin
                           loop_ff[ch_ff] <= 1'b1;
                           pc_ff[ch_ff]   <= fd;
                        end else begin
                           loop_ff[ch_ff] <= 1'b0;
                           pc_ff[ch_ff]   <= nxt;
                        end
                     end else begin
                        idx_ff       <= {1'b0, meas_ff[ch_ff] ? fa : fc};
                        cnt_ff       <= meas_ff[ch_ff] ? fb : fd;
                        pc_ff[ch_ff] <= nxt;
                     end
                     state_ff <= S_CPY;
                  end
                  default: begin
                     k_ff     <= '0;
                     st_ff    <= ST_ERR;
                     state_ff <= S_STAT;
                  end
               endcase
            end
            S_CPY: begin
               if (copy_go) begin
                  cnt_ff   <= cnt_ff - 16'd1;
                  idx_ff   <= idx_ff + 17'd1;
                  state_ff <= S_CPW;
               end else if (k_ff != '0) begin
                  st_ff    <= ST_OK;
                  state_ff <= S_STAT;
               end else begin
                  state_ff <= S_CHECK;
               end
            end
            S_CPW: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_kind_ff  <= 1'b0;
                  rsp_lo_ff    <= rd_lo_ff;
                  rsp_hi_ff    <= rd_hi_ff;
                  rsp_cnt_ff   <= '0;
                  rsp_st_ff    <= ST_OK;
                  rsp_meas_ff  <= 1'b0;
                  rsp_last_ff  <= 1'b0;
                  k_ff         <= k_ff + KW'(1);
                  state_ff     <= S_CPY;
               end
            end
            S_STAT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_kind_ff  <= 1'b1;
                  rsp_lo_ff    <= '0;
                  rsp_hi_ff    <= '0;
                  rsp_cnt_ff   <= 5'(k_ff);
                  rsp_st_ff    <= st_ff;
                  rsp_meas_ff  <= bad_ff ? 1'b0 : meas_ff[ch_ff];
                  rsp_last_ff  <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.kind           = rsp_kind_ff;
   assign rsp_bus.micro_lo       = rsp_lo_ff;
   assign rsp_bus.micro_hi       = rsp_hi_ff;
   assign rsp_bus.produced_count = rsp_cnt_ff;
   assign rsp_bus.status         = rsp_st_ff;
   assign rsp_bus.measured       = rsp_meas_ff;
   assign rsp_bus.last           = rsp_last_ff;

   `MIE_ASSERT_NOW(a_k_within_cap, clock, reset,
      (state_ff != S_IDLE) && !bad_ff, k_ff <= cap_ff, "emit count exceeds capacity")
   `MIE_ASSERT_NOW(a_walk_bounded, clock, reset,
      state_ff != S_IDLE, 32'(visits_ff) <= WALK_LIMIT, "walk limit overrun")
   `MIE_ASSERT_NEXT(a_status_ends_run, clock, reset,
      (state_ff == S_STAT) && out_free, rsp_valid_ff && rsp_last_ff && (state_ff == S_IDLE),
      "status beat did not close the run")
endmodule
`default_nettype wire

// ----- tb/tb_macro_instruction_expander_unit.sv -----
`timescale 1ns / 1ps
module tb_macro_instruction_expander_unit;
   import mie_pkg::*;

   localparam int NCH       = 4;
   localparam int DEPTH     = 256;
   localparam int BATCH_MAX = 16;
   localparam int PROG_LEN  = 16;
   localparam int HOLD_CYCLES = 300;
   localparam int STALL_LIMIT = 5000;
   localparam logic [1:0] OP_IGNORED = 2'd3;
   localparam logic [7:0] OPC_STOP   = 8'hFF;

   typedef struct {
      logic        kind;
      logic [63:0] lo;
      logic [63:0] hi;
      logic [4:0]  count;
      logic [1:0]  status;
      logic        measured;
      logic        last;
   } beat_type;

   logic clock;
   logic reset;

   mie_req_if req_if();
   mie_rsp_if rsp_if();
   mie_csr_if csr_if();

   macro_instruction_expander_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .csr_bus (csr_if)
   );

   // shadow of the block
   logic [63:0] prog_lo [NCH][DEPTH];
   logic [63:0] prog_hi [NCH][DEPTH];
   logic [15:0] pc_sh [NCH];
   logic        loop_sh [NCH];
   logic [15:0] iter_sh [NCH];
   logic        meas_sh [NCH];
   logic        test_mode_sh;
   logic        test_result_sh;

   beat_type expected_beats[$];
   int    errors;
   int    idle_cycles;
   bit    tx_idling;
   bit    rx_idling;
   bit    hold_req;

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   function automatic beat_type micro_beat(logic [63:0] lo, logic [63:0] hi);
      beat_type b;
      b = '{1'b0, lo, hi, 5'd0, ST_OK, 1'b0, 1'b0};
      return b;
   endfunction

   function automatic beat_type status_beat(int k, logic [1:0] st, logic m);
      beat_type b;
      b = '{1'b1, 64'd0, 64'd0, 5'(k), st, m, 1'b1};
      return b;
   endfunction

   function automatic void copy_entries(int ch, int start, int cnt, int n, int cap,
                                        ref beat_type q[$]);
      for (int i = 0; i < cnt && q.size() < cap; i++) begin
         if (start + i >= n) break;
         q.push_back(micro_beat(prog_lo[ch][start + i], prog_hi[ch][start + i]));
      end
   endfunction

   function automatic void predict_update(int ch, int cnt_in, int cap_in, logic cam);
      beat_type    q[$];
      int          n, cap, visits, pc;
      logic [1:0]  st;
      bit          stop;
      logic [63:0] lo, hi;
      logic [7:0]  opc;
      int          fa, fb, fc, fd;
      n = cnt_in > DEPTH ? DEPTH : cnt_in;
      cap = cap_in > BATCH_MAX ? BATCH_MAX : cap_in;
      visits = 0;
      stop = 0;
      st = ST_DONE;
      if (int'(pc_sh[ch]) >= n) stop = 1;
      while (!stop && int'(pc_sh[ch]) < n && q.size() < cap) begin
         pc = int'(pc_sh[ch]);
         lo = prog_lo[ch][pc];
         hi = prog_hi[ch][pc];
         opc = hi[63:56];
         if (visits >= WALK_LIMIT) begin
            st = ST_OK;
            stop = 1;
            break;
         end
         visits++;
         if (opc == OPC_MICRO) begin
            q.push_back(micro_beat(lo, hi));
            pc_sh[ch] = 16'(pc + 1);
            if (q.size() == cap) begin
               st = ST_OK;
               stop = 1;
            end
         end else if (opc == OPC_MEAS) begin
            if (q.size() > 0) begin
               st = ST_OK;
               stop = 1;
            end else begin
               meas_sh[ch] = test_mode_sh ? test_result_sh : cam;
               pc_sh[ch] = 16'(pc + 1);
            end
         end else if (opc == OPC_BRANCH) begin
            fa = int'(hi[31:16]);
            fb = int'(hi[15:0]);
            fc = int'(lo[63:48]);
            fd = int'(lo[47:32]);
            pc_sh[ch] = 16'(pc + 1);
            if (hi[55:48] == BR_LOOP && fa > 0 && fb > 0) begin
               if (!loop_sh[ch]) begin
                  loop_sh[ch] = 1'b1;
                  iter_sh[ch] = 16'(fb);
               end
               copy_entries(ch, fc, fa, n, cap, q);
               iter_sh[ch] = iter_sh[ch] - 16'd1;
               if (iter_sh[ch] > 0) pc_sh[ch] = 16'(fd);
               else begin
                  loop_sh[ch] = 1'b0;
                  pc_sh[ch] = hi[47:32];
               end
            end else begin
               if (meas_sh[ch]) copy_entries(ch, fa, fb, n, cap, q);
               else copy_entries(ch, fc, fd, n, cap, q);
               pc_sh[ch] = hi[47:32];
            end
            if (q.size() > 0) begin
               st = ST_OK;
               stop = 1;
            end
         end else begin
            foreach (q[i]) expected_beats.push_back(q[i]);
            expected_beats.push_back(status_beat(0, ST_ERR, meas_sh[ch]));
            return;
         end
      end
      if (!stop) st = (int'(pc_sh[ch]) >= n) ? ST_DONE : (q.size() > 0 ? ST_OK : ST_DONE);
      foreach (q[i]) expected_beats.push_back(q[i]);
      expected_beats.push_back(status_beat(q.size(), st, meas_sh[ch]));
   endfunction

   function automatic void clear_channels();
      for (int c = 0; c < NCH; c++) begin
         pc_sh[c] = '0;
         loop_sh[c] = 1'b0;
         iter_sh[c] = '0;
         meas_sh[c] = 1'b0;
      end
   endfunction

   task automatic send_item(logic [1:0] op, logic [1:0] ch, logic [7:0] addr, logic half,
                            logic [63:0] word, logic [8:0] cnt, logic [4:0] cap,
                            logic cam);
      int gap;
      gap = tx_idling ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.op           <= op;
      req_if.channel      <= ch;
      req_if.entry_addr   <= addr;
      req_if.half_sel     <= half;
      req_if.write_word   <= word;
      req_if.entry_count  <= cnt;
      req_if.capacity     <= cap;
      req_if.camera_ready <= cam;
      do @(posedge clock); while (!req_if.ready);
      case (op)
         OP_WRITE: begin
            if (half) prog_hi[ch][addr] = word;
            else prog_lo[ch][addr] = word;
         end
         OP_CLEAR: clear_channels();
         OP_UPDATE: predict_update(int'(ch), int'(cnt), int'(cap), cam);
         default: ;
      endcase
   endtask

   task automatic stop_sending();
      req_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      while (expected_beats.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic val);
      drain();
      csr_if.valid <= 1'b1;
      csr_if.addr  <= idx;
      csr_if.wdata <= val;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      if (idx == CSR_TEST_MODE) test_mode_sh = val;
      else test_result_sh = val;
      @(posedge clock);
   endtask

   function automatic logic [63:0] random_word();
      return {$urandom(), $urandom()};
   endfunction

   // branch targets stay inside the loaded program; its last entry stops any walk that reaches it
   function automatic logic [63:0] random_hi();
      int          r;
      logic [63:0] w;
      r = $urandom_range(0, 99);
      w = random_word();
      if (r < 65) w[63:56] = OPC_MICRO;
      else if (r < 77) w[63:56] = OPC_MEAS;
      else if (r < 97) begin
         w[63:56] = OPC_BRANCH;
         w[55:48] = ($urandom_range(0, 2) != 0) ? BR_LOOP : 8'($urandom());
         w[47:32] = 16'($urandom_range(0, PROG_LEN - 2));
         w[31:16] = 16'($urandom_range(0, 6));
         w[15:0]  = 16'($urandom_range(0, 4));
      end else w[63:56] = 8'($urandom_range(3, 255));
      return w;
   endfunction

   function automatic logic [63:0] random_lo();
      logic [63:0] w;
      w = random_word();
      w[63:48] = 16'($urandom_range(0, 8));
      w[47:32] = 16'($urandom_range(0, 8));
      return w;
   endfunction

   task automatic random_update(int max_count);
      logic [8:0] cnt;
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) cnt = 9'(DEPTH);
      else if (r == 1) cnt = 9'($urandom_range(257, 511));
      else cnt = 9'($urandom_range(0, max_count));
      send_item(OP_UPDATE, 2'($urandom()), 8'($urandom()), 1'($urandom()), random_word(),
                cnt, 5'($urandom_range(0, 31)), 1'($urandom()));
   endtask

   task automatic test_load_programs();
      logic [63:0] hi;
      tx_idling = 0;
      for (int c = 0; c < NCH; c++)
         for (int a = 0; a < PROG_LEN; a++) begin
            hi = (a == PROG_LEN - 1) ? {OPC_STOP, 56'($urandom())} : random_hi();
            send_item(OP_WRITE, 2'(c), 8'(a), 1'b0, random_lo(), '0, '0, 1'b0);
            send_item(OP_WRITE, 2'(c), 8'(a), 1'b1, hi, '0, '0, 1'b0);
         end
      tx_idling = 1;
   endtask

   task automatic test_directed();
      send_item(OP_WRITE, 2'd3, 8'd0, 1'b1, {OPC_MEAS, 56'hFF_FFFF_FFFF_FFFF}, '0, '0, 1'b0);
      send_item(OP_WRITE, 2'd3, 8'd1, 1'b1, {OPC_STOP, 56'd0}, '0, '0, 1'b0);
      send_item(OP_WRITE, 2'd3, 8'd2, 1'b1, {OPC_MICRO, 56'd0}, '0, '0, 1'b0);
      send_item(OP_UPDATE, 2'd3, 8'd0, 1'b0, '0, 9'd0, 5'd16, 1'b1);
      send_item(OP_UPDATE, 2'd3, 8'd0, 1'b0, '0, 9'd8, 5'd0, 1'b1);
      send_item(OP_UPDATE, 2'd3, 8'd0, 1'b0, '0, 9'd8, 5'd31, 1'b1);
      send_item(OP_UPDATE, 2'd3, 8'd0, 1'b0, '0, 9'd8, 5'd16, 1'b0);
      send_item(OP_IGNORED, 2'd3, 8'd0, 1'b0, '1, 9'd511, 5'd31, 1'b1);
      send_item(OP_CLEAR, 2'd3, 8'd0, 1'b0, '0, '0, '0, 1'b0);
      send_item(OP_UPDATE, 2'd3, 8'd0, 1'b0, '0, 9'd511, 5'd1, 1'b1);
      send_item(OP_UPDATE, 2'd0, 8'd0, 1'b0, '0, 9'd256, 5'd16, 1'b0);
      send_item(OP_UPDATE, 2'd1, 8'd0, 1'b0, '0, 9'd511, 5'd31, 1'b1);
      write_csr(CSR_TEST_MODE, 1'b1);
      write_csr(CSR_TEST_RESULT, 1'b1);
      send_item(OP_CLEAR, 2'd0, 8'd0, 1'b0, '0, '0, '0, 1'b0);
      send_item(OP_UPDATE, 2'd3, 8'd0, 1'b0, '0, 9'd1, 5'd1, 1'b0);
      send_item(OP_UPDATE, 2'd2, 8'd0, 1'b0, '0, 9'd64, 5'd16, 1'b0);
      write_csr(CSR_TEST_RESULT, 1'b0);
      send_item(OP_UPDATE, 2'd2, 8'd0, 1'b0, '0, 9'd64, 5'd16, 1'b1);
      write_csr(CSR_TEST_MODE, 1'b0);
   endtask

   task automatic test_backpressure();
      hold_req = 1;
      tx_idling = 0;
      send_item(OP_CLEAR, 2'd0, 8'd0, 1'b0, '0, '0, '0, 1'b0);
      repeat (20) send_item(OP_UPDATE, 2'($urandom()), 8'd0, 1'b0, '0, 9'd48, 5'd16,
                            1'($urandom()));
      tx_idling = 1;
      drain();
   endtask

   task automatic test_random();
      int r;
      for (int i = 0; i < 180; i++) begin
         if (i % 80 == 79) begin
            write_csr(CSR_TEST_MODE, 1'($urandom()));
            write_csr(CSR_TEST_RESULT, 1'($urandom()));
         end
         tx_idling = (i % 100) >= 20;
         rx_idling = (i % 100) < 60 || (i % 100) >= 80;
         r = $urandom_range(0, 99);
         if (r < 58) random_update(48);
         else if (r < 88) begin
            if ($urandom_range(0, 1))
               send_item(OP_WRITE, 2'($urandom()), 8'($urandom_range(0, PROG_LEN - 2)), 1'b1,
                         random_hi(), 9'($urandom()), 5'($urandom()), 1'($urandom()));
            else
               send_item(OP_WRITE, 2'($urandom()), 8'($urandom()), 1'b0, random_lo(),
                         9'($urandom()), 5'($urandom()), 1'($urandom()));
         end else if (r < 96)
            send_item(OP_CLEAR, 2'($urandom()), 8'($urandom()), 1'($urandom()),
                      random_word(), 9'($urandom()), 5'($urandom()), 1'($urandom()));
         else
            send_item(OP_IGNORED, 2'($urandom()), 8'($urandom()), 1'($urandom()),
                      random_word(), 9'($urandom()), 5'($urandom()), 1'($urandom()));
      end
      tx_idling = 1;
      rx_idling = 1;
   endtask

   initial begin
      reset <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.op <= OP_WRITE;
      req_if.channel <= '0;
      req_if.entry_addr <= '0;
      req_if.half_sel <= 1'b0;
      req_if.write_word <= '0;
      req_if.entry_count <= '0;
      req_if.capacity <= '0;
      req_if.camera_ready <= 1'b0;
      csr_if.valid <= 1'b0;
      csr_if.addr <= CSR_TEST_MODE;
      csr_if.wdata <= 1'b0;
      errors = 0;
      hold_req = 0;
      tx_idling = 1;
      rx_idling = 1;
      test_mode_sh = 1'b0;
      test_result_sh = 1'b0;
      clear_channels();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_load_programs();
      test_directed();
      test_backpressure();
      test_random();
      drain();
      if (errors == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

   initial begin
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         int gap;
         gap = rx_idling ? $urandom_range(0, 11) : 0;
         if (hold_req) begin
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_req = 0;
         end else if (gap > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
      end
   end

   always @(posedge clock) begin
      beat_type exp_b;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_beats.size() == 0) begin
            $error("unexpected result beat, kind %0d status %0d", rsp_if.kind, rsp_if.status);
            errors++;
         end else begin
            exp_b = expected_beats.pop_front();
            if (rsp_if.kind !== exp_b.kind) begin
               $error("kind: expected %0h actual %0h", exp_b.kind, rsp_if.kind);
               errors++;
            end
            if (rsp_if.micro_lo !== exp_b.lo) begin
               $error("micro_lo: expected %0h actual %0h", exp_b.lo, rsp_if.micro_lo);
               errors++;
            end
            if (rsp_if.micro_hi !== exp_b.hi) begin
               $error("micro_hi: expected %0h actual %0h", exp_b.hi, rsp_if.micro_hi);
               errors++;
            end
            if (rsp_if.produced_count !== exp_b.count) begin
               $error("produced_count: expected %0d actual %0d", exp_b.count,
                      rsp_if.produced_count);
               errors++;
            end
            if (rsp_if.status !== exp_b.status) begin
               $error("status: expected %0d actual %0d", exp_b.status, rsp_if.status);
               errors++;
            end
            if (rsp_if.measured !== exp_b.measured) begin
               $error("measured: expected %0h actual %0h", exp_b.measured, rsp_if.measured);
               errors++;
            end
            if (rsp_if.last !== exp_b.last) begin
               $error("last: expected %0h actual %0h", exp_b.last, rsp_if.last);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial idle_cycles = 0;
endmodule
